// ===== hw/rtl/lru_key_value_cache_top_macros.svh =====
// -----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// Same-cycle implication.
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
// -----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, controller state codes and controller/datapath interfaces.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AGE_W       = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_EV_RD  = 6'b000100,
    S_EV_WB  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } lkvc_state_e;

  typedef struct packed {
    logic load_req;
    logic scan;
    logic evict_rd;
    logic evict_wb;
    logic update;
    logic load_result;
  } lkvc_cmd_t;

  typedef struct packed {
    logic             key_match;
    logic             scan_last;
    logic             need_evict;
    logic             lru_found;
    logic [CNT_W-1:0] occupancy;
  } lkvc_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkvc_ctrl.sv =====
// -----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences scan, eviction, update and result handoff for one request.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire lkvc_sts_t sts_i,
  output lkvc_cmd_t      cmd_o
);

  lkvc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.key_match) begin
          state_d = S_UPDATE;
        end else if (sts_i.scan_last) begin
          state_d = sts_i.need_evict ? S_EV_RD : S_UPDATE;
        end
      end
      S_EV_RD: begin
        cmd_o.evict_rd = 1'b1;
        state_d        = S_EV_WB;
      end
      S_EV_WB: begin
        cmd_o.evict_wb = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_dpath.sv =====
// -----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key and value memories, per-entry valid and age ranks, scan and result regs.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_dpath
  import lkvc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                    command_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire lkvc_cmd_t               cmd_i,
  output lkvc_sts_t                    sts_o,
  output logic                         hit_o,
  output logic signed [VAL_W-1:0]      read_value_o,
  output logic                         evicted_o,
  output logic signed [KEY_W-1:0]      evicted_key_o
);

  logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_val_q;
  logic [IDX_W-1:0] rd_addr;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] cap_eff;

  logic             put_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  logic [IDX_W-1:0] scan_idx_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic             key_match;

  logic             hit_q;
  logic [IDX_W-1:0] found_idx_q;
  logic [VAL_W-1:0] found_val_q;
  logic             ev_q;
  logic [KEY_W-1:0] ev_key_q;

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [AGE_W-1:0]       age_q [MAX_ENTRIES];
  logic [AGE_W-1:0]       age_d [MAX_ENTRIES];
  logic [CNT_W-1:0]       occ_q, occ_d;

  logic [AGE_W-1:0] lru_age;
  logic [IDX_W-1:0] lru_idx;
  logic             lru_found;
  logic [IDX_W-1:0] slot_idx;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CAP_W'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      put_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  // Memory read port: scan address, or the LRU entry during eviction
  assign rd_addr = cmd_i.evict_rd ? lru_idx : scan_idx_q;

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && put_q) begin
      if (hit_q) begin
        val_mem[found_idx_q] <= val_q;
      end else begin
        key_mem[slot_idx] <= key_q;
        val_mem[slot_idx] <= val_q;
      end
    end
  end

  // Scan pipeline: issue one address per cycle, compare in the cycle after
  assign key_match = cmp_vld_q && valid_q[cmp_idx_q] && (rd_key_q == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      ev_q       <= 1'b0;
    end else if (cmd_i.load_req) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      ev_q       <= 1'b0;
    end else begin
      if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
        cmp_idx_q  <= scan_idx_q;
        cmp_vld_q  <= 1'b1;
        if (key_match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.evict_wb) begin
        ev_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && key_match) begin
      found_idx_q <= cmp_idx_q;
      found_val_q <= rd_val_q;
    end
    if (cmd_i.evict_wb) begin
      ev_key_q <= rd_key_q;
    end
  end

  // Least recent entry holds rank occupancy-1
  assign lru_age = AGE_W'(occ_q - CNT_W'(1));

  always_comb begin
    lru_idx   = '0;
    lru_found = 1'b0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (valid_q[j] && (age_q[j] == lru_age)) begin
        lru_idx   = lru_idx | IDX_W'(j);
        lru_found = 1'b1;
      end
    end
  end

  // Lowest free entry
  always_comb begin
    slot_idx = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        slot_idx = IDX_W'(j);
      end
    end
  end

  // Valid, age and occupancy update
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    occ_d   = occ_q;
    if (cmd_i.evict_wb) begin
      valid_d[lru_idx] = 1'b0;
      occ_d            = occ_q - CNT_W'(1);
    end
    if (cmd_i.update) begin
      if (hit_q) begin
        // promote: entries younger than the hit entry age by one
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          if (valid_q[j] && (age_q[j] < age_q[found_idx_q])) begin
            age_d[j] = age_q[j] + AGE_W'(1);
          end
        end
        age_d[found_idx_q] = '0;
      end else if (put_q) begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          if (valid_q[j]) begin
            age_d[j] = age_q[j] + AGE_W'(1);
          end
        end
        valid_d[slot_idx] = 1'b1;
        age_d[slot_idx]   = '0;
        occ_d             = occ_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      hit_o     <= hit_q;
      evicted_o <= ev_q;
      if (put_q) begin
        read_value_o <= '0;
      end else if (hit_q) begin
        read_value_o <= found_val_q;
      end else begin
        read_value_o <= '1;
      end
      evicted_key_o <= ev_q ? ev_key_q : '0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.key_match  = key_match;
    sts_o.scan_last  = cmp_vld_q && (cmp_idx_q == IDX_W'(MAX_ENTRIES - 1));
    sts_o.need_evict = put_q && (occ_q >= cap_eff);
    sts_o.lru_found  = lru_found;
    sts_o.occupancy  = occ_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// -----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative 16-entry key-value store with least-recently-used
// replacement.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: command_i
//   (0 = get, 1 = put), key_i and value_i. Output channel
//   (out_valid_o/out_ready_i) returns one result per request: hit_o,
//   read_value_o (-1 on a get miss, 0 for a put), evicted_o, evicted_key_o.
//   cfg_we_i writes the capacity register from cfg_wdata_i; write it only
//   while no request is in flight.
//   One request is processed at a time. The key memory is scanned one entry
//   per cycle through its single read port; a key match ends the scan early,
//   and a put miss with the store at capacity reads and writes back the LRU
//   entry before the update, after which the result is loaded.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; a stalled receiver holds the next
//   request at its final step until the output register frees up.
//   Reset empties the store (all entries invalid) and sets capacity to 16.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_top_macros.svh"

module lru_key_value_cache_top
  import lkvc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    command_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         hit_o,
  output logic signed [VAL_W-1:0]      read_value_o,
  output logic                         evicted_o,
  output logic signed [KEY_W-1:0]      evicted_key_o
);

  lkvc_cmd_t dp_cmd;
  lkvc_sts_t dp_sts;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  lkvc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  `LKVC_ASSERT_NEXT(a_busy_after_accept, dp_cmd.load_req, !in_ready_o, "input not blocked")
  `LKVC_ASSERT_NOW(a_occ_bound, 1'b1, dp_sts.occupancy <= CNT_W'(MAX_ENTRIES), "occupancy too high")
  `LKVC_ASSERT_NOW(a_lru_exists, dp_cmd.evict_rd, dp_sts.lru_found, "no LRU entry to evict")
  `LKVC_ASSERT_NOW(a_evict_on_miss, out_valid_o && evicted_o, !hit_o, "eviction on a hit")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put requests with random gaps and output stalls, and keeps a
// shadow copy of the store with its recency ranks. Each result is compared
// with the shadow's prediction. Capacity is changed between drained phases,
// including out-of-range values and drops below the current occupancy.
// -----------------------------------------------------------------------------

import lkvc_pkg::*;

typedef struct packed {
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
} lookup_outcome_t;

class lru_shadow;
  logic [KEY_W-1:0] keys [MAX_ENTRIES];
  logic [VAL_W-1:0] vals [MAX_ENTRIES];
  bit               live [MAX_ENTRIES];
  int unsigned      age  [MAX_ENTRIES];
  int unsigned      fill;
  logic [CAP_W-1:0] cap;
  lookup_outcome_t  due [$];
  int unsigned      mismatches;

  function new();
    foreach (live[i]) begin
      live[i] = 1'b0;
      keys[i] = '0;
      vals[i] = '0;
      age[i]  = 0;
    end
    fill       = 0;
    cap        = CAP_RESET;
    mismatches = 0;
  endfunction

  // Zero acts as one, anything past the store size acts as the store size.
  function int unsigned limit();
    if (cap == 0) return 1;
    if (cap > MAX_ENTRIES) return MAX_ENTRIES;
    return cap;
  endfunction

  function void note_request(bit put, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
    lookup_outcome_t r;
    int              found;
    int              lru;
    int              slot;
    int unsigned     oldest;
    int unsigned     rank;
    r      = '0;
    found  = -1;
    lru    = -1;
    slot   = -1;
    oldest = 0;
    foreach (live[i])
      if (found < 0 && live[i] && keys[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (put) vals[found] = data;
      else r.read_value = vals[found];
      // promote: everything younger than the hit entry ages by one
      rank = age[found];
      foreach (live[i])
        if (live[i] && age[i] < rank) age[i]++;
      age[found] = 0;
    end else if (!put) begin
      r.read_value = '1;
    end else begin
      if (fill >= limit()) begin
        foreach (live[i])
          if (live[i] && (lru < 0 || age[i] > oldest)) begin
            lru    = i;
            oldest = age[i];
          end
        if (lru >= 0) begin
          r.evicted     = 1'b1;
          r.evicted_key = keys[lru];
          live[lru]     = 1'b0;
          if (fill > 0) fill--;
        end
      end
      foreach (live[i])
        if (slot < 0 && !live[i]) slot = i;
      if (slot >= 0) begin
        foreach (live[i])
          if (live[i]) age[i]++;
        live[slot] = 1'b1;
        keys[slot] = key;
        vals[slot] = data;
        age[slot]  = 0;
        fill++;
      end
    end
    due.push_back(r);
  endfunction

  function void check_result(logic hit, logic [VAL_W-1:0] rv, logic ev,
                             logic [KEY_W-1:0] ek);
    lookup_outcome_t want;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with no request pending: hit=%0b value=%h evicted=%0b key=%h",
                 hit, rv, ev, ek);
      return;
    end
    want = due.pop_front();
    if (hit !== want.hit || rv !== want.read_value || ev !== want.evicted ||
        ek !== want.evicted_key) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected hit=%0b value=%h evicted=%0b key=%h, got hit=%0b value=%h evicted=%0b key=%h",
                 want.hit, want.read_value, want.evicted, want.evicted_key,
                 hit, rv, ev, ek);
    end
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 70;
  localparam logic [CAP_W-1:0] CAP_PLAN [PHASES] = '{
    5'd4, 5'd31, 5'd1, 5'd16, 5'd9, 5'd3, 5'd17, 5'd12, 5'd0
  };

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] ALL_ONES = 32'hffff_ffff;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    command_i   = 1'b0;
  logic signed [KEY_W-1:0] key_i       = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    hit_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic                    evicted_o;
  logic signed [KEY_W-1:0] evicted_key_o;

  lru_shadow        shadow;
  bit               calm = 1'b0;
  int unsigned      cycle_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lru_key_value_cache_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      shadow.check_result(hit_o, read_value_o, evicted_o, evicted_key_o);
  end

  initial begin
    int unsigned hold;
    forever begin
      out_ready_i <= 1'b1;
      repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk_i);
      if (!calm) begin
        hold = pick_gap();
        if (hold > 0) begin
          out_ready_i <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
      end
    end
  end

  // Valid stays high on return; the next request replaces it or, after a gap, takes it down, as does settle_cache.
  task automatic send_request(bit put, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= put;
    key_i      <= key;
    value_i    <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_request(put, key, data);
  endtask

  // Hold off new requests until every pending result has come back.
  task automatic settle_cache();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.due.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.cap = cap;
  endtask

  initial begin
    int unsigned      span;
    int unsigned      base;
    logic [KEY_W-1:0] key;
    shadow = new();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = ALL_ONES;
    key_pool[3] = '0;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, extreme keys and values, update in place, ignored value on get.
    send_request(1'b0, '0, '0);
    send_request(1'b1, KEY_MIN, KEY_MAX);
    send_request(1'b1, KEY_MAX, KEY_MIN);
    send_request(1'b1, ALL_ONES, ALL_ONES);
    send_request(1'b1, '0, '0);
    send_request(1'b0, KEY_MIN, '0);
    send_request(1'b0, ALL_ONES, '0);
    send_request(1'b1, KEY_MAX, 32'h1234_5678);
    send_request(1'b0, KEY_MAX, '0);
    send_request(1'b0, 32'h0000_0001, '0);
    send_request(1'b0, '0, 32'hdead_beef);
    settle_cache();

    // Small capacity: eviction order follows recency, not insertion.
    // The store still holds four entries, so the first put evicts right away.
    set_capacity(5'd2);
    send_request(1'b1, 32'h0000_00a1, 32'h1111_1111);
    send_request(1'b1, 32'h0000_00b2, 32'h2222_2222);
    send_request(1'b0, 32'h0000_00a1, '0);
    send_request(1'b1, 32'h0000_00c3, 32'h3333_3333);
    send_request(1'b0, 32'h0000_00b2, '0);
    send_request(1'b1, 32'h0000_00b2, 32'h4444_4444);
    settle_cache();

    // Zero capacity behaves as one while the store stays over-full.
    set_capacity(5'd0);
    send_request(1'b1, 32'h0000_00d4, 32'h5555_5555);
    send_request(1'b1, 32'h0000_00e5, 32'h6666_6666);
    send_request(1'b0, 32'h0000_00d4, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle_cache();
      set_capacity(CAP_PLAN[p]);
      calm = (p % 3 == 2);
      for (int i = 0; i < 3; i++) key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      span = shadow.limit() + $urandom_range(1, 4);
      if (span > POOL_SIZE) span = POOL_SIZE;
      base = $urandom_range(0, POOL_SIZE - 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[(base + $urandom_range(0, span - 1)) % POOL_SIZE];
        send_request(1'($urandom_range(0, 1)), key, $urandom);
      end
    end

    calm = 1'b0;
    settle_cache();
    repeat (30) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
